[hw/rtl/zdr_pkg.sv]
// zdr_pkg: shared types, constants and helpers of the dead reckoning update block
// used by the controller, the datapath, the register write channel and the top level
`timescale 1ns / 1ps
`default_nettype none

package zdr_pkg;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP_SPEED = 4'd1;

  localparam logic [23:0] SAMPLE_PERIOD_RST = 24'd167772;
  localparam logic [23:0] MIN_STEP_SPEED_RST = 24'd655;

  // fixed point constants
  localparam logic signed [32:0] G_Q16 = 33'sd642689;
  localparam logic signed [32:0] DEG2RAD_Q32 = 33'sd74961321;
  localparam logic signed [32:0] NUDGE_Q24 = 33'sd167772;
  localparam logic signed [16:0] ONE_G_Q12 = 17'sd4096;
  localparam logic signed [33:0] ONE_G_Q28 = 34'sd268435456;

  localparam logic [6:0] STEP_LAST = 7'd67;
  localparam logic [6:0] ROOT_FIRST = 7'd22;
  localparam logic [6:0] ROOT_LAST = 7'd53;

  typedef enum logic [5:0] {
    OP_NOP,
    OP_LOAD,
    OP_MCG0, OP_MCG1, OP_MCG2,
    OP_MID16,
    OP_MMIDT,
    OP_VEL0, OP_VEL1, OP_VEL2,
    OP_MGD,
    OP_MID8,
    OP_HEAD,
    OP_MSQ0, OP_MSQ1,
    OP_SQ_FIRST, OP_SQ_ADD,
    OP_ROOT_INIT, OP_ROOT_STEP,
    OP_STEP,
    OP_MNG0, OP_MNG1, OP_MNG2,
    OP_BIAS0, OP_BIAS1, OP_BIAS2,
    OP_ZERO,
    OP_MVT0, OP_MVT1, OP_MVT2,
    OP_POS0, OP_POS1, OP_POS2,
    OP_CAP
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  // micro-op sequence of one sample, step 0 being the load beat
  function automatic op_t seq_op(input logic [6:0] step);
    op_t op;
    op = OP_NOP;
    if (step >= ROOT_FIRST && step <= ROOT_LAST) begin
      op = OP_ROOT_STEP;
    end else begin
      case (step)
        7'd1:  op = OP_MCG0;
        7'd2:  op = OP_MID16;
        7'd3:  op = OP_MMIDT;
        7'd4:  op = OP_VEL0;
        7'd5:  op = OP_MCG1;
        7'd6:  op = OP_MID16;
        7'd7:  op = OP_MMIDT;
        7'd8:  op = OP_VEL1;
        7'd9:  op = OP_MCG2;
        7'd10: op = OP_MID16;
        7'd11: op = OP_MMIDT;
        7'd12: op = OP_VEL2;
        7'd13: op = OP_MGD;
        7'd14: op = OP_MID8;
        7'd15: op = OP_MMIDT;
        7'd16: op = OP_HEAD;
        7'd17: op = OP_MSQ0;
        7'd18: op = OP_SQ_FIRST;
        7'd19: op = OP_MSQ1;
        7'd20: op = OP_SQ_ADD;
        7'd21: op = OP_ROOT_INIT;
        7'd54: op = OP_STEP;
        7'd55: op = OP_MNG0;
        7'd56: op = OP_BIAS0;
        7'd57: op = OP_MNG1;
        7'd58: op = OP_BIAS1;
        7'd59: op = OP_MNG2;
        7'd60: op = OP_BIAS2;
        7'd61: op = OP_ZERO;
        7'd62: op = OP_MVT0;
        7'd63: op = OP_POS0;
        7'd64: op = OP_MVT1;
        7'd65: op = OP_POS1;
        7'd66: op = OP_MVT2;
        7'd67: op = OP_POS2;
        default: op = OP_NOP;
      endcase
    end
    return op;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > 50'sd140737488355327) r = 48'sh7fffffffffff;
    else if (v < -50'sd140737488355328) r = 48'sh800000000000;
    else r = v[47:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/zdr_in_if.sv]
// zdr_in_if: input channel carrying one imu sample per beat
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface zdr_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_z;
  logic in_stance;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_z, in_stance, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_z, in_stance, output ready);
endinterface

`default_nettype wire

[hw/rtl/zdr_out_if.sv]
// zdr_out_if: result channel carrying position, velocity, heading and step data
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface zdr_out_if;
  logic valid;
  logic ready;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic signed [47:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] heading;
  logic [31:0] steps;
  logic [31:0] stride;
  logic [47:0] distance;
  logic step_taken;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, heading,
                  steps, stride, distance, step_taken, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, heading,
                steps, stride, distance, step_taken, output ready);
endinterface

`default_nettype wire

[hw/rtl/zdr_cfg_if.sv]
// zdr_cfg_if: register write channel
// depends on zdr_pkg for widths
`timescale 1ns / 1ps
`default_nettype none

interface zdr_cfg_if;
  logic valid;
  logic ready;
  logic [zdr_pkg::CFG_IDX_W-1:0] idx;
  logic [zdr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/zdr_ctrl.sv]
// zdr_ctrl: sequencer stepping the datapath through one sample, plus channel handshakes
// depends on zdr_pkg
`timescale 1ns / 1ps
`default_nettype none

module zdr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output zdr_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} state_t;

  state_t state_r, state_nxt;
  logic [6:0] step_r, step_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd.op = zdr_pkg::OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = zdr_pkg::OP_LOAD;
          state_nxt = S_RUN;
          step_nxt = 7'd1;
        end
      end
      S_RUN: begin
        cmd.op = zdr_pkg::seq_op(step_r);
        step_nxt = step_r + 7'd1;
        if (step_r == zdr_pkg::STEP_LAST) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        // result register free or being emptied this beat
        if (!out_valid_r || out_ready) begin
          cmd.op = zdr_pkg::OP_CAP;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[hw/rtl/zdr_dp.sv]
// zdr_dp: datapath with shared multiplier, bit-serial square root, state and result registers
// depends on zdr_pkg
`timescale 1ns / 1ps
`default_nettype none

module zdr_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire zdr_pkg::cmd_t                      cmd,
  input  wire logic signed [15:0]                 accel_x,
  input  wire logic signed [15:0]                 accel_y,
  input  wire logic signed [15:0]                 accel_z,
  input  wire logic signed [15:0]                 gyro_z,
  input  wire logic                               in_stance,
  input  wire logic                               cfg_we,
  input  wire logic [zdr_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [zdr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic signed [47:0]                      pos_x,
  output logic signed [47:0]                      pos_y,
  output logic signed [47:0]                      pos_z,
  output logic signed [31:0]                      vel_x,
  output logic signed [31:0]                      vel_y,
  output logic signed [31:0]                      vel_z,
  output logic signed [31:0]                      heading,
  output logic [31:0]                             steps,
  output logic [31:0]                             stride,
  output logic [47:0]                             distance,
  output logic                                    step_taken
);

  logic [23:0] period_r, min_speed_r;

  logic signed [15:0] ax_r, ay_r, az_r, gz_r;
  logic stance_r;
  logic signed [33:0] c_r [3];
  logic signed [37:0] mid_r;
  logic signed [70:0] prod_r;
  logic [63:0] sq_r, rem_r, root_r, bit_r;

  logic signed [31:0] bias_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [47:0] pos_r [3];
  logic signed [31:0] heading_r;
  logic [31:0] stride_r, steps_r;
  logic [47:0] dist_r;
  logic taken_r;

  logic signed [37:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [32:0] period_b;
  logic signed [70:0] r16, r8, r24, r36;
  logic [63:0] trial;
  logic [48:0] dist_sum;

  assign period_b = signed'({9'd0, period_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      zdr_pkg::OP_MCG0: begin mul_a = 38'(c_r[0]); mul_b = zdr_pkg::G_Q16; end
      zdr_pkg::OP_MCG1: begin mul_a = 38'(c_r[1]); mul_b = zdr_pkg::G_Q16; end
      zdr_pkg::OP_MCG2: begin mul_a = 38'(c_r[2]); mul_b = zdr_pkg::G_Q16; end
      zdr_pkg::OP_MMIDT: begin mul_a = mid_r; mul_b = period_b; end
      zdr_pkg::OP_MGD: begin mul_a = 38'(gz_r); mul_b = zdr_pkg::DEG2RAD_Q32; end
      zdr_pkg::OP_MSQ0: begin mul_a = 38'(vel_r[0]); mul_b = 33'(vel_r[0]); end
      zdr_pkg::OP_MSQ1: begin mul_a = 38'(vel_r[1]); mul_b = 33'(vel_r[1]); end
      zdr_pkg::OP_MNG0: begin mul_a = 38'(ax_r); mul_b = zdr_pkg::NUDGE_Q24; end
      zdr_pkg::OP_MNG1: begin mul_a = 38'(ay_r); mul_b = zdr_pkg::NUDGE_Q24; end
      zdr_pkg::OP_MNG2: begin
        mul_a = 38'(17'(az_r) - zdr_pkg::ONE_G_Q12);
        mul_b = zdr_pkg::NUDGE_Q24;
      end
      zdr_pkg::OP_MVT0: begin mul_a = 38'(vel_r[0]); mul_b = period_b; end
      zdr_pkg::OP_MVT1: begin mul_a = 38'(vel_r[1]); mul_b = period_b; end
      zdr_pkg::OP_MVT2: begin mul_a = 38'(vel_r[2]); mul_b = period_b; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // round half up then floor shift of the registered product
  assign r8  = (prod_r + 71'sd128) >>> 8;
  assign r16 = (prod_r + 71'sd32768) >>> 16;
  assign r24 = (prod_r + 71'sd8388608) >>> 24;
  assign r36 = (prod_r + 71'sd34359738368) >>> 36;

  assign trial = root_r + bit_r;
  assign dist_sum = {1'b0, dist_r} + {17'd0, root_r[31:0]};

  always_ff @(posedge clk) begin
    prod_r <= 71'(mul_a) * 71'(mul_b);
    case (cmd.op)
      zdr_pkg::OP_LOAD: begin
        ax_r <= accel_x;
        ay_r <= accel_y;
        az_r <= accel_z;
        gz_r <= gyro_z;
        stance_r <= in_stance;
        c_r[0] <= 34'(signed'({accel_x, 16'd0})) - 34'(bias_r[0]);
        c_r[1] <= 34'(signed'({accel_y, 16'd0})) - 34'(bias_r[1]);
        c_r[2] <= 34'(signed'({accel_z, 16'd0})) - 34'(bias_r[2]) - zdr_pkg::ONE_G_Q28;
      end
      zdr_pkg::OP_MID16: mid_r <= r16[37:0];
      zdr_pkg::OP_MID8: mid_r <= r8[37:0];
      zdr_pkg::OP_SQ_FIRST: sq_r <= prod_r[63:0];
      zdr_pkg::OP_SQ_ADD: sq_r <= sq_r + prod_r[63:0];
      zdr_pkg::OP_ROOT_INIT: begin
        rem_r <= sq_r;
        root_r <= '0;
        bit_r <= 64'd1 << 62;
      end
      zdr_pkg::OP_ROOT_STEP: begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      zdr_pkg::OP_CAP: begin
        pos_x <= pos_r[0];
        pos_y <= pos_r[1];
        pos_z <= pos_r[2];
        vel_x <= vel_r[0];
        vel_y <= vel_r[1];
        vel_z <= vel_r[2];
        heading <= heading_r;
        steps <= steps_r;
        stride <= stride_r;
        distance <= dist_r;
        step_taken <= taken_r;
      end
      default: ;
    endcase
  end

  // accumulated state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= zdr_pkg::SAMPLE_PERIOD_RST;
      min_speed_r <= zdr_pkg::MIN_STEP_SPEED_RST;
      bias_r[0] <= '0;
      bias_r[1] <= '0;
      bias_r[2] <= '0;
      vel_r[0] <= '0;
      vel_r[1] <= '0;
      vel_r[2] <= '0;
      pos_r[0] <= '0;
      pos_r[1] <= '0;
      pos_r[2] <= '0;
      heading_r <= '0;
      stride_r <= '0;
      steps_r <= '0;
      dist_r <= '0;
      taken_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          zdr_pkg::REG_SAMPLE_PERIOD: period_r <= cfg_data;
          zdr_pkg::REG_MIN_STEP_SPEED: min_speed_r <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        zdr_pkg::OP_VEL0: vel_r[0] <= zdr_pkg::sat32(40'(vel_r[0]) + 40'(signed'(r36[33:0])));
        zdr_pkg::OP_VEL1: vel_r[1] <= zdr_pkg::sat32(40'(vel_r[1]) + 40'(signed'(r36[33:0])));
        zdr_pkg::OP_VEL2: vel_r[2] <= zdr_pkg::sat32(40'(vel_r[2]) + 40'(signed'(r36[33:0])));
        zdr_pkg::OP_HEAD:
          heading_r <= zdr_pkg::sat32(40'(heading_r) + 40'(signed'(r24[37:0])));
        zdr_pkg::OP_STEP: begin
          taken_r <= 1'b0;
          if (stance_r && (root_r > {40'd0, min_speed_r})) begin
            taken_r <= 1'b1;
            stride_r <= root_r[31:0];
            dist_r <= dist_sum[48] ? '1 : dist_sum[47:0];
            steps_r <= steps_r + 32'd1;
          end
        end
        zdr_pkg::OP_BIAS0:
          if (stance_r) bias_r[0] <= zdr_pkg::sat32(40'(bias_r[0]) + 40'(signed'(r8[33:0])));
        zdr_pkg::OP_BIAS1:
          if (stance_r) bias_r[1] <= zdr_pkg::sat32(40'(bias_r[1]) + 40'(signed'(r8[33:0])));
        zdr_pkg::OP_BIAS2:
          if (stance_r) bias_r[2] <= zdr_pkg::sat32(40'(bias_r[2]) + 40'(signed'(r8[33:0])));
        zdr_pkg::OP_ZERO: begin
          if (stance_r) begin
            vel_r[0] <= '0;
            vel_r[1] <= '0;
            vel_r[2] <= '0;
          end
        end
        zdr_pkg::OP_POS0:
          pos_r[0] <= zdr_pkg::sat48(50'(pos_r[0]) + 50'(signed'(r24[47:0])));
        zdr_pkg::OP_POS1:
          pos_r[1] <= zdr_pkg::sat48(50'(pos_r[1]) + 50'(signed'(r24[47:0])));
        zdr_pkg::OP_POS2:
          pos_r[2] <= zdr_pkg::sat48(50'(pos_r[2]) + 50'(signed'(r24[47:0])));
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/zupt_dead_reckoning_update.sv]
// Zero-velocity-update dead reckoning, one imu sample in, one navigation result out.
// in_s: valid/ready channel, one sample per beat (accelerations Q3.12 g, yaw rate
//   1/16 deg/s, stance flag). ready is high only while no sample is in work.
// out_s: valid/ready channel, one result per sample: position, velocity, heading,
//   step count, last stride, distance and a step flag.
// cfg_s: register writes (index 0 sample period, 1 step speed threshold), always
//   ready; unknown indexes are dropped. Write only while the block is idle.
// Sequencing: one shared multiplier is used sixteen times in turn and a square root is
//   resolved one result bit per cycle, 32 bits in all; no new sample is taken while
//   one is in work, and the next sample can be taken the cycle after the result is
//   registered.
// Receiver stall: a finished result sits in the output register while the next
//   sample is accepted and worked; if that one finishes first it waits in the
//   datapath until the output register empties.
// Reset (synchronous, rst_n low): all accumulators, biases and counts clear,
//   registers take their default values, no result is pending.
// Depends on zdr_pkg, zdr_in_if, zdr_out_if, zdr_cfg_if, zdr_ctrl and zdr_dp.
`timescale 1ns / 1ps
`default_nettype none

module zupt_dead_reckoning_update (
  input  wire logic   clk,
  input  wire logic   rst_n,
  zdr_in_if.sink      in_s,
  zdr_out_if.source   out_s,
  zdr_cfg_if.sink     cfg_s
);

  zdr_pkg::cmd_t cmd;

  assign cfg_s.ready = 1'b1;

  zdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_s.valid),
    .in_ready  (in_s.ready),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .cmd       (cmd)
  );

  zdr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .accel_x    (in_s.accel_x),
    .accel_y    (in_s.accel_y),
    .accel_z    (in_s.accel_z),
    .gyro_z     (in_s.gyro_z),
    .in_stance  (in_s.in_stance),
    .cfg_we     (cfg_s.valid),
    .cfg_idx    (cfg_s.idx),
    .cfg_data   (cfg_s.data),
    .pos_x      (out_s.pos_x),
    .pos_y      (out_s.pos_y),
    .pos_z      (out_s.pos_z),
    .vel_x      (out_s.vel_x),
    .vel_y      (out_s.vel_y),
    .vel_z      (out_s.vel_z),
    .heading    (out_s.heading),
    .steps      (out_s.steps),
    .stride     (out_s.stride),
    .distance   (out_s.distance),
    .step_taken (out_s.step_taken)
  );

endmodule

`default_nettype wire

[bench/tb.sv]
// tb: self-checking bench for the dead reckoning update block
// predicts each navigation result in fixed point and compares field by field
// depends on zdr_pkg, zdr_in_if, zdr_out_if, zdr_cfg_if and the block itself
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic signed [47:0] pos_x, pos_y, pos_z;
    logic signed [31:0] vel_x, vel_y, vel_z, heading;
    logic [31:0] steps, stride;
    logic [47:0] distance;
    logic step_taken;
  } nav_t;

  logic clk = 0;
  logic rst_n = 0;

  zdr_in_if in_c();
  zdr_out_if out_c();
  zdr_cfg_if cfg_c();

  zupt_dead_reckoning_update i_dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_c.sink), .out_s(out_c.source), .cfg_s(cfg_c.sink)
  );

  initial forever #4 clk = ~clk;

  // predictor state
  longint unsigned period_q, thresh_q;
  longint bias_q[3], vel_q[3], pos_q[3];
  longint head_q;
  longint unsigned stride_q, dist_q, steps_q;

  nav_t nav_expected[$];
  int fail_count = 0;
  longint cycles = 0;
  int burst_left = 0;
  bit stall_mode = 0;

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void predictor_reset();
    period_q = 64'(zdr_pkg::SAMPLE_PERIOD_RST);
    thresh_q = 64'(zdr_pkg::MIN_STEP_SPEED_RST);
    for (int i = 0; i < 3; i++) begin
      bias_q[i] = 0; vel_q[i] = 0; pos_q[i] = 0;
    end
    head_q = 0; stride_q = 0; dist_q = 0; steps_q = 0;
  endfunction

  function automatic nav_t predict_nav(logic signed [15:0] a[3], logic signed [15:0] gz,
                                       logic stance);
    nav_t r;
    longint c, t, aa;
    longint unsigned spd;
    bit took;
    t = longint'(period_q);
    took = 0;
    for (int i = 0; i < 3; i++) begin
      c = longint'(a[i]) * 65536 - bias_q[i] - (i == 2 ? 268435456 : 0);
      vel_q[i] = clamp(vel_q[i] + round_shift(round_shift(c * 642689, 16) * t, 36), 32);
    end
    head_q = clamp(head_q + round_shift(round_shift(longint'(gz) * 74961321, 8) * t, 24),
                   32);
    if (stance) begin
      spd = int_sqrt(longint'(vel_q[0] * vel_q[0]) + longint'(vel_q[1] * vel_q[1]));
      if (spd > thresh_q) begin
        stride_q = spd & 64'hffff_ffff;
        dist_q += spd;
        if (dist_q > 64'hffff_ffff_ffff) dist_q = 64'hffff_ffff_ffff;
        steps_q = (steps_q + 1) & 64'hffff_ffff;
        took = 1;
      end
      for (int i = 0; i < 3; i++) begin
        aa = longint'(a[i]) - (i == 2 ? 4096 : 0);
        bias_q[i] = clamp(bias_q[i] + round_shift(aa * 167772, 8), 32);
        vel_q[i] = 0;
      end
    end
    for (int i = 0; i < 3; i++) pos_q[i] = clamp(pos_q[i] + round_shift(vel_q[i] * t, 24), 48);
    r.pos_x = pos_q[0][47:0]; r.pos_y = pos_q[1][47:0]; r.pos_z = pos_q[2][47:0];
    r.vel_x = vel_q[0][31:0]; r.vel_y = vel_q[1][31:0]; r.vel_z = vel_q[2][31:0];
    r.heading = head_q[31:0]; r.steps = steps_q[31:0]; r.stride = stride_q[31:0];
    r.distance = dist_q[47:0]; r.step_taken = took;
    return r;
  endfunction

  task automatic send_sample(logic signed [15:0] ax, ay, az, gz, logic stance);
    logic signed [15:0] a[3];
    while (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) @(posedge clk);
      else burst_left = int'($urandom_range(1, 12));
    end
    burst_left--;
    in_c.valid <= 1;
    in_c.accel_x <= ax; in_c.accel_y <= ay; in_c.accel_z <= az;
    in_c.gyro_z <= gz; in_c.in_stance <= stance;
    a[0] = ax; a[1] = ay; a[2] = az;
    nav_expected.push_back(predict_nav(a, gz, stance));
    @(posedge clk);
    while (!in_c.ready) @(posedge clk);
    in_c.valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [zdr_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
    while (nav_expected.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_c.valid <= 1; cfg_c.idx <= idx; cfg_c.data <= val;
    @(posedge clk);
    while (!cfg_c.ready) @(posedge clk);
    cfg_c.valid <= 0;
    if (idx == zdr_pkg::REG_SAMPLE_PERIOD) period_q = 64'(val);
    else if (idx == zdr_pkg::REG_MIN_STEP_SPEED) thresh_q = 64'(val);
  endtask

  task automatic send_random(int n, int stance_pct, bit wide);
    logic signed [15:0] ax, ay, az;
    for (int i = 0; i < n; i++) begin
      if (wide) begin
        ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
      end else begin
        ax = 16'(int'($urandom_range(0, 2000)) - 1000);
        ay = 16'(int'($urandom_range(0, 2000)) - 1000);
        az = 16'(4096 + int'($urandom_range(0, 600)) - 300);
      end
      send_sample(ax, ay, az, 16'($urandom), int'($urandom_range(0, 99)) < stance_pct);
    end
  endtask

  task automatic test_field_extremes();
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send_sample(16'sh7fff, 16'sh0000, 16'sh7fff, 16'sh7fff, 1);
    send_sample(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 0);
    send_sample(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 1);
    send_sample(16'sd0, 16'sd0, 16'sd4096, 16'sd0, 1);
    send_sample(16'sh5555, -16'sh2aab, 16'sd0, 16'sh5555, 0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1);
  endtask

  // stride exactly at the threshold must not count as a step
  task automatic test_step_threshold();
    write_reg(zdr_pkg::REG_MIN_STEP_SPEED, 24'd0);
    send_sample(16'sd0, 16'sd0, 16'sd4096, 16'sd0, 1);
    send_sample(16'sd100, 16'sd0, 16'sd4096, 16'sd0, 0);
    send_sample(16'sd0, 16'sd0, 16'sd4096, 16'sd0, 1);
    write_reg(zdr_pkg::REG_MIN_STEP_SPEED, 24'hffffff);
    send_sample(16'sh7fff, 16'sh7fff, 16'sd4096, 16'sd0, 0);
    send_sample(16'sd0, 16'sd0, 16'sd4096, 16'sd0, 1);
    write_reg(zdr_pkg::REG_MIN_STEP_SPEED, zdr_pkg::MIN_STEP_SPEED_RST);
  endtask

  task automatic test_zero_period();
    write_reg(zdr_pkg::REG_SAMPLE_PERIOD, 24'd0);
    send_sample(16'sd1000, -16'sd1000, 16'sd5000, 16'sd300, 0);
    send_sample(16'sd1000, -16'sd1000, 16'sd5000, 16'sd300, 1);
    write_reg(4'd7, 24'd5);
    write_reg(4'd15, 24'd9);
    send_sample(-16'sd50, 16'sd20, 16'sd4000, -16'sd9, 0);
    write_reg(zdr_pkg::REG_SAMPLE_PERIOD, 24'hffffff);
    send_sample(16'sd200, 16'sd300, 16'sd4200, 16'sd100, 0);
    send_sample(16'sd200, 16'sd300, 16'sd4200, 16'sd100, 1);
    write_reg(zdr_pkg::REG_SAMPLE_PERIOD, 24'd1);
    send_sample(-16'sd200, 16'sd300, 16'sd4000, -16'sd100, 1);
  endtask

  task automatic test_random_walk();
    write_reg(zdr_pkg::REG_SAMPLE_PERIOD, zdr_pkg::SAMPLE_PERIOD_RST);
    send_random(250, 25, 0);
    write_reg(zdr_pkg::REG_SAMPLE_PERIOD, 24'd1000000);
    write_reg(zdr_pkg::REG_MIN_STEP_SPEED, 24'd30000);
    send_random(200, 20, 0);
    write_reg(zdr_pkg::REG_SAMPLE_PERIOD, 24'($urandom_range(1, 24'hffffff)));
    write_reg(zdr_pkg::REG_MIN_STEP_SPEED, 24'($urandom_range(0, 24'hffffff)));
    send_random(120, 30, 1);
    write_reg(zdr_pkg::REG_SAMPLE_PERIOD, 24'hffffff);
    write_reg(zdr_pkg::REG_MIN_STEP_SPEED, 24'd0);
    send_random(100, 40, 1);
  endtask

  // receiver stall pattern, alternating free-flowing and stalled stretches
  always @(posedge clk) begin
    cycles++;
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    out_c.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    nav_t got, exp_nav;
    if (rst_n && out_c.valid && out_c.ready) begin
      got.pos_x = out_c.pos_x; got.pos_y = out_c.pos_y; got.pos_z = out_c.pos_z;
      got.vel_x = out_c.vel_x; got.vel_y = out_c.vel_y; got.vel_z = out_c.vel_z;
      got.heading = out_c.heading; got.steps = out_c.steps; got.stride = out_c.stride;
      got.distance = out_c.distance; got.step_taken = out_c.step_taken;
      if (nav_expected.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result beat: %p", got);
      end else begin
        exp_nav = nav_expected.pop_front();
        if (got !== exp_nav) begin
          fail_count++;
          if (fail_count <= 10) $display("mismatch\n  exp %p\n  got %p", exp_nav, got);
        end
      end
    end
  end

  initial begin
    in_c.valid = 0; in_c.accel_x = 0; in_c.accel_y = 0; in_c.accel_z = 0;
    in_c.gyro_z = 0; in_c.in_stance = 0;
    cfg_c.valid = 0; cfg_c.idx = 0; cfg_c.data = 0;
    out_c.ready = 0;
    predictor_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_field_extremes();
    test_step_threshold();
    test_zero_period();
    test_random_walk();
    while (nav_expected.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
